// ===== hdl/base32_text_decoder_defines.svh =====
// Assertion macros shared by the Base32 text decoder RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef BASE32_TEXT_DECODER_DEFINES_SVH
`define BASE32_TEXT_DECODER_DEFINES_SVH

// Check cons in the cycle after ante holds.
`define B32TD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check cons in the same cycle as ante.
`define B32TD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/b32td_pkg.sv =====
// Constants, types and the character map of the Base32 text decoder.
// No dependencies; imported by base32_text_decoder.
`default_nettype none

package b32td_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_BYTE = 2'd0;
    localparam t_kind KIND_END  = 2'd1;
    localparam t_kind KIND_BAD  = 2'd2;

    localparam int unsigned SYM_W   = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned STORE_W = 12;
    localparam int unsigned HELD_W  = 3;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 9'd256;

    localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] CH_LF    = 8'h0A;
    localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_ONE   = 8'h31;
    localparam logic [SYM_W-1:0] CH_TWO   = 8'h32;
    localparam logic [SYM_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [SYM_W-1:0] CH_EIGHT = 8'h38;
    localparam logic [SYM_W-1:0] CH_UB    = 8'h42;
    localparam logic [SYM_W-1:0] CH_UL    = 8'h4C;
    localparam logic [SYM_W-1:0] CH_UO    = 8'h4F;
    localparam logic [SYM_W-1:0] CH_LA    = 8'h61;
    localparam logic [SYM_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [SYM_W-1:0] CASE_BIT = 8'h20;
    localparam logic [SYM_W-1:0] DIGIT_BIAS = 8'd24;

    // Return {valid, value} for one character.
    function automatic logic [5:0] b32td_digit(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] m;
        logic [SYM_W-1:0] low;
        logic [SYM_W-1:0] diff;
        m = c;
        if (c == CH_ZERO) begin
            m = CH_UO;
        end else if (c == CH_ONE) begin
            m = CH_UL;
        end else if (c == CH_EIGHT) begin
            m = CH_UB;
        end
        low  = m | CASE_BIT;
        diff = m - DIGIT_BIAS;
        if (low >= CH_LA && low <= CH_LZ) begin
            return {1'b1, m[4:0] - 5'd1};
        end else if (m >= CH_TWO && m <= CH_SEVEN) begin
            return {1'b1, diff[4:0]};
        end
        return 6'd0;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/base32_text_decoder.sv =====
// Base32 text decoder: one character in, at most one result out.
// Usage:
//   Input channel (i_valid/o_stall, i_symbol) takes one character per item.
//   Space, tab, CR, LF and dash produce no result. Letters, 2-7 and the
//   look-alike digits 0, 1, 8 feed 5 bits each; a byte item leaves whenever
//   8 bits are held. Any other nonzero character gives one invalid item and
//   mutes the string. A zero character gives an end item with the count and
//   clears the string state. Muted or at capacity, other input is dropped.
//   Output channel (o_valid/i_stall) carries kind, data byte and count.
//   Config channel (i_cfg_valid/o_cfg_ready) writes capacity, always ready;
//   write it only while the block is idle.
// Timing: o_valid rises after the input register and then the result
//   register; throughput one item per cycle while i_stall is low, set by
//   the state update between the two registers.
// Reset: synchronous, active low; clears both stages and string state and
//   sets capacity to 256.
// Stall: while a result is held under i_stall, the input register holds and
//   o_stall rises once it is full; no item is lost or repeated.
// Depends on b32td_pkg and base32_text_decoder_defines.svh.
`default_nettype none

`include "base32_text_decoder_defines.svh"

module base32_text_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [b32td_pkg::SYM_W-1:0]   i_symbol,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output b32td_pkg::t_kind                   o_kind,
    output logic [7:0]                         o_data_byte,
    output logic [b32td_pkg::COUNT_W-1:0]      o_byte_count,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [b32td_pkg::COUNT_W-1:0] i_cfg_capacity
);
    import b32td_pkg::*;

    logic                 r_in_valid;
    logic [SYM_W-1:0]     r_sym;
    logic [COUNT_W-1:0]   r_capacity;
    logic [STORE_W-1:0]   r_bit_store, n_bit_store;
    logic [HELD_W-1:0]    r_bits_held, n_bits_held;
    logic [COUNT_W-1:0]   r_produced, n_produced;
    logic                 r_discarding, n_discarding;
    logic                 r_out_valid, n_out_valid;
    t_kind                r_kind, n_kind;
    logic [7:0]           r_data, n_data;
    logic [COUNT_W-1:0]   r_count, n_count;

    logic                 adv;
    logic                 in_acc;
    logic                 work;
    logic [5:0]           dig;
    logic [STORE_W-1:0]   shifted;
    logic [HELD_W:0]      sum;
    logic [HELD_W:0]      sh;
    logic [STORE_W-1:0]   aligned;
    logic                 skip;

    assign adv         = !(r_out_valid && i_stall);
    assign o_stall     = r_in_valid && !adv;
    assign in_acc      = i_valid && !o_stall;
    assign work        = r_in_valid && adv;
    assign o_cfg_ready = 1'b1;

    assign dig     = b32td_digit(r_sym);
    assign shifted = {r_bit_store[STORE_W-6:0], dig[4:0]};
    assign sum     = {1'b0, r_bits_held} + 4'd5;
    assign sh      = sum - 4'd8;
    assign aligned = shifted >> sh;
    assign skip    = r_sym == CH_SPACE || r_sym == CH_TAB || r_sym == CH_CR
                  || r_sym == CH_LF || r_sym == CH_DASH;

    always_comb begin
        n_bit_store  = r_bit_store;
        n_bits_held  = r_bits_held;
        n_produced   = r_produced;
        n_discarding = r_discarding;
        n_out_valid  = 1'b0;
        n_kind       = KIND_BYTE;
        n_data       = 8'd0;
        n_count      = r_produced;
        if (r_sym == CH_NUL) begin
            n_out_valid  = 1'b1;
            n_kind       = KIND_END;
            n_bit_store  = '0;
            n_bits_held  = '0;
            n_produced   = '0;
            n_discarding = 1'b0;
        end else if (r_discarding || r_produced >= r_capacity || skip) begin
            n_out_valid = 1'b0;
        end else if (!dig[5]) begin
            n_discarding = 1'b1;
            n_out_valid  = 1'b1;
            n_kind       = KIND_BAD;
        end else begin
            n_bit_store = shifted;
            if (sum[HELD_W]) begin
                n_bits_held = sh[HELD_W-1:0];
                n_produced  = r_produced + 9'd1;
                n_out_valid = 1'b1;
                n_data      = aligned[7:0];
                n_count     = r_produced + 9'd1;
            end else begin
                n_bits_held = sum[HELD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_capacity   <= CAPACITY_RESET;
            r_bit_store  <= '0;
            r_bits_held  <= '0;
            r_produced   <= '0;
            r_discarding <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_capacity;
            end
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (work) begin
                r_bit_store  <= n_bit_store;
                r_bits_held  <= n_bits_held;
                r_produced   <= n_produced;
                r_discarding <= n_discarding;
            end
            if (adv) begin
                r_out_valid <= work && n_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sym <= i_symbol;
        end
        if (adv) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_count <= n_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_data_byte  = r_data;
    assign o_byte_count = r_count;

    `B32TD_ASSERT_NEXT(a_end_clears, work && r_sym == CH_NUL,
        r_produced == '0 && r_bits_held == '0 && !r_discarding,
        "terminator did not clear string state")
    `B32TD_ASSERT_SAME(a_byte_count, o_valid && o_kind == KIND_BYTE,
        o_byte_count != '0, "byte item with zero count")
    `B32TD_ASSERT_SAME(a_data_zero, o_valid && o_kind != KIND_BYTE,
        o_data_byte == 8'd0, "nonzero data on non-byte item")
    `B32TD_ASSERT_NEXT(a_in_hold, r_in_valid && !adv,
        r_in_valid && $stable(r_sym), "input register lost item under stall")

endmodule

`default_nettype wire

// ===== test/base32_text_decoder_tb.sv =====
// Self-checking testbench for base32_text_decoder: a queue-fed driver, a checking
// monitor and a character-level decoder predictor that tracks capacity writes.
// Depends on b32td_pkg and the base32_text_decoder RTL.
`default_nettype none

module base32_text_decoder_tb;

    import b32td_pkg::*;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic [COUNT_W-1:0] count;
    } t_decoded;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_PHASES   = 8;

    localparam logic [SYM_W-1:0] OPENING [22] = '{
        CH_NUL, "A", "z", CH_TWO, CH_SEVEN, CH_ZERO, CH_ONE, CH_EIGHT,
        CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_DASH, "Q", "=", "M", CH_NUL,
        "G", "E", 8'hFF, "Y", CH_NUL
    };

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic [SYM_W-1:0]   in_symbol    = '0;
    logic               out_stall    = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic [COUNT_W-1:0] cfg_capacity = '0;

    logic               o_stall;
    logic               o_valid;
    t_kind              o_kind;
    logic [7:0]         o_data_byte;
    logic [COUNT_W-1:0] o_byte_count;
    logic               o_cfg_ready;

    logic [SYM_W-1:0] chars_to_send [$];
    t_decoded         expected_results [$];

    logic [STORE_W-1:0] bit_store  = '0;
    int                 bits_held  = 0;
    logic [COUNT_W-1:0] produced   = '0;
    bit                 discarding = 1'b0;
    logic [COUNT_W-1:0] capacity   = CAPACITY_RESET;

    int idle_pct = 9;
    int cycles   = 0;
    bit failed   = 1'b0;

    base32_text_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_symbol       (in_symbol),
        .o_valid        (o_valid),
        .i_stall        (out_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_byte_count   (o_byte_count),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (cfg_capacity)
    );

    always #4 clk = ~clk;

    function automatic bit is_blank(input logic [SYM_W-1:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_DASH};
    endfunction

    function automatic int char_value(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] u;
        u = c;
        if (c == CH_ZERO) begin
            u = CH_UO;
        end else if (c == CH_ONE) begin
            u = CH_UL;
        end else if (c == CH_EIGHT) begin
            u = CH_UB;
        end
        if (u >= "A" && u <= "Z") return int'(u - "A");
        if (u >= "a" && u <= "z") return int'(u - "a");
        if (u >= CH_TWO && u <= CH_SEVEN) return int'(u - CH_TWO) + 26;
        return -1;
    endfunction

    function automatic void decode_char(input logic [SYM_W-1:0] c);
        int       v;
        t_decoded r;
        r = '0;
        if (c == CH_NUL) begin
            r.kind  = KIND_END;
            r.count = produced;
            expected_results.push_back(r);
            bit_store  = '0;
            bits_held  = 0;
            produced   = '0;
            discarding = 1'b0;
            return;
        end
        if (discarding || produced >= capacity || is_blank(c)) return;
        v = char_value(c);
        if (v < 0) begin
            discarding = 1'b1;
            r.kind     = KIND_BAD;
            r.count    = produced;
            expected_results.push_back(r);
            return;
        end
        bit_store = {bit_store[STORE_W-6:0], 5'(v)};
        bits_held += 5;
        if (bits_held >= 8) begin
            bits_held -= 8;
            produced = produced + 1'b1;
            r.kind   = KIND_BYTE;
            r.data   = 8'(bit_store >> bits_held);
            r.count  = produced;
            expected_results.push_back(r);
        end
    endfunction

    function automatic logic [SYM_W-1:0] encode_value(input int v);
        logic [SYM_W-1:0] c;
        if (v >= 26) return CH_TWO + SYM_W'(v - 26);
        c = "A" + SYM_W'(v);
        if ($urandom_range(0, 3) == 0) begin
            if (c == CH_UO) return CH_ZERO;
            if (c == CH_UL) return CH_ONE;
            if (c == CH_UB) return CH_EIGHT;
        end
        if ($urandom_range(0, 1)) c = c | CASE_BIT;
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] bad_char();
        logic [SYM_W-1:0] c;
        do begin
            c = SYM_W'($urandom_range(1, 255));
        end while (char_value(c) >= 0 || is_blank(c));
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] blank_char();
        case ($urandom_range(0, 4))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_LF;
            default: return CH_DASH;
        endcase
    endfunction

    task automatic add_string(input int len, input int bad_pct);
        int r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < bad_pct) begin
                chars_to_send.push_back(bad_char());
            end else if (r < bad_pct + 8) begin
                chars_to_send.push_back(blank_char());
            end else begin
                chars_to_send.push_back(encode_value($urandom_range(0, 31)));
            end
        end
        chars_to_send.push_back(CH_NUL);
    endtask

    task automatic fill_random(input int count);
        int len;
        int pick;
        while (chars_to_send.size() < count) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
            if (pick < 80) begin
                add_string(len, 0);
            end else if (pick < 95) begin
                add_string(len, 4);
            end else begin
                for (int i = 0; i < len; i++) begin
                    chars_to_send.push_back(SYM_W'($urandom_range(0, 255)));
                end
                chars_to_send.push_back(CH_NUL);
            end
        end
    endtask

    task automatic drain();
        do begin
            @(posedge clk);
        end while (chars_to_send.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        cfg_valid    <= 1'b1;
        cfg_capacity <= value;
        do begin
            @(posedge clk);
        end while (!o_cfg_ready);
        capacity = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                decode_char(in_symbol);
            end
            if (!in_valid || !o_stall) begin
                if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_valid  <= 1'b1;
                    in_symbol <= chars_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_decoded want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %s %0d %0d %0d",
                             $time, "kind/byte/count", o_kind, o_data_byte,
                             o_byte_count);
                    failed = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte", want.data, o_data_byte);
                    check_field("byte_count", want.count, o_byte_count);
                end
            end
            out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [COUNT_W-1:0] cap;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[i]) chars_to_send.push_back(OPENING[i]);
        // fill past the reset capacity, then an invalid character that must be dropped
        for (int i = 0; i < 420; i++) begin
            chars_to_send.push_back(encode_value($urandom_range(0, 31)));
        end
        chars_to_send.push_back(bad_char());
        chars_to_send.push_back(CH_NUL);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: cap = 9'd1;
                1: cap = 9'd511;
                2: cap = 9'd0;
                3: cap = COUNT_W'($urandom_range(2, 40));
                4: cap = 9'd256;
                5: cap = COUNT_W'($urandom_range(1, 12));
                6: cap = 9'd2;
                default: cap = COUNT_W'($urandom_range(257, 510));
            endcase
            idle_pct = (p == 4) ? 0 : 9;
            write_capacity(cap);
            fill_random((p == 2) ? 60 : 200);
            drain();
        end

        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
